FILE: rtl/core/dapc_pkg.sv
// ----------------------------------------------------------------------------
// dapc_pkg
// shared types and constants of the depth and alpha pixel compositor
// ----------------------------------------------------------------------------
`default_nettype none

package dapc_pkg;

  localparam int NumStages = 5;

  localparam logic [7:0]  ByteMax  = 8'hFF;
  localparam logic [31:0] FarDepth = 32'hFFFF_FFFF;

  // floor(t / 255) for t < 2**16 as (t * AlphaRecip) >> AlphaShift
  localparam int          AlphaShift = 24;
  localparam logic [16:0] AlphaRecip = 17'(((33'd1 << AlphaShift) + 33'd254) / 33'd255);

  // floor(x / 65025) for x < 2**25 as (x * BandRecip) >> BandShift
  localparam int          BandShift = 41;
  localparam logic [25:0] BandRecip =
    26'(((64'd1 << BandShift) + 64'd65024) / 64'd65025);

  // per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } dapc_en_t;

  // stage 1 result shared by the band lanes
  typedef struct packed {
    logic [15:0] dst_coef;
    logic [15:0] src_coef;
    logic [31:0] depth;
  } dapc_coef_t;

endpackage

`default_nettype wire

FILE: rtl/core/dapc_coef.sv
// ----------------------------------------------------------------------------
// dapc_coef
// depth test and blend weights, first pipeline stage
// ----------------------------------------------------------------------------
`default_nettype none

module dapc_coef import dapc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en1,
  input  wire logic [7:0]  src_alpha,
  input  wire logic [31:0] src_depth,
  input  wire logic [7:0]  dst_alpha,
  input  wire logic [31:0] dst_depth,
  input  wire logic        first_layer,
  output dapc_coef_t       coef
);

  logic [31:0] acc_depth;
  logic        nearer;
  logic [7:0]  dst_mul;
  logic [7:0]  src_mul;

  always_comb begin
    // missing or ignored accumulated depth is infinitely far
    acc_depth = ((dst_depth == '0) || first_layer) ? FarDepth : dst_depth;
    // a missing incoming depth lands behind the accumulated one
    nearer    = (src_depth != '0) && (src_depth < acc_depth);
    dst_mul   = nearer ? (ByteMax - src_alpha) : ByteMax;
    src_mul   = nearer ? ByteMax : (ByteMax - dst_alpha);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      coef.dst_coef <= {8'd0, dst_alpha} * {8'd0, dst_mul};
      coef.src_coef <= {8'd0, src_alpha} * {8'd0, src_mul};
      coef.depth    <= nearer ? src_depth : dst_depth;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dapc_band.sv
// ----------------------------------------------------------------------------
// dapc_band
// one color band: weighted sum, divide by 255*255, saturate
// ----------------------------------------------------------------------------
`default_nettype none

module dapc_band import dapc_pkg::*; (
  input  wire logic       clk,
  input  wire dapc_en_t   en,
  input  wire logic [7:0] src_band,
  input  wire logic [7:0] dst_band,
  input  wire dapc_coef_t coef,
  output logic [7:0]      out_band
);

  logic [7:0]  src1;
  logic [7:0]  dst1;
  logic [23:0] dst_prod;
  logic [23:0] src_prod;
  logic [24:0] sum;
  logic [50:0] scaled;
  logic [9:0]  quot;

  assign quot = scaled[BandShift +: 10];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      src1 <= src_band;
      dst1 <= dst_band;
    end
    if (en.s2) begin
      dst_prod <= {16'd0, dst1} * {8'd0, coef.dst_coef};
      src_prod <= {16'd0, src1} * {8'd0, coef.src_coef};
    end
    if (en.s3) begin
      sum <= {1'b0, dst_prod} + {1'b0, src_prod};
    end
    if (en.s4) begin
      scaled <= {26'd0, sum} * {25'd0, BandRecip};
    end
    if (en.s5) begin
      out_band <= (quot > 10'd255) ? ByteMax : quot[7:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dapc_cov.sv
// ----------------------------------------------------------------------------
// dapc_cov
// merged coverage: b + a*(255-b)/255
// ----------------------------------------------------------------------------
`default_nettype none

module dapc_cov import dapc_pkg::*; (
  input  wire logic       clk,
  input  wire dapc_en_t   en,
  input  wire logic [7:0] src_alpha,
  input  wire logic [7:0] dst_alpha,
  output logic [7:0]      out_alpha
);

  logic [15:0] cov_prod;
  logic [7:0]  dst1;
  logic [32:0] scaled;
  logic [7:0]  dst2;
  logic [7:0]  alpha3;
  logic [7:0]  alpha4;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      cov_prod <= {8'd0, src_alpha} * {8'd0, ByteMax - dst_alpha};
      dst1     <= dst_alpha;
    end
    if (en.s2) begin
      scaled <= {17'd0, cov_prod} * {16'd0, AlphaRecip};
      dst2   <= dst1;
    end
    // quotient never exceeds 255 - dst, so the sum fits a byte
    if (en.s3) begin
      alpha3 <= dst2 + scaled[AlphaShift +: 8];
    end
    if (en.s4) begin
      alpha4 <= alpha3;
    end
    if (en.s5) begin
      out_alpha <= alpha4;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/depth_alpha_pixel_compositor_top.sv
// ----------------------------------------------------------------------------
// depth_alpha_pixel_compositor_top
// merges one layer pixel into the accumulated pixel with a depth test
// ----------------------------------------------------------------------------
//
// channel   dir  width  contents
// s_axis    in   128+1  layer pixel and accumulated pixel, first-layer flag
// m_axis    out  64     merged pixel
//
// one beat per clock while m_axis_tready stays high; each beat passes the
// five register stages in order (weights, band products, sum, reciprocal
// multiply, saturate)
// rst clears the stage valid bits only; data registers hold whatever
// each stage moves when the next one can take it, so bubbles are squeezed
// out and a stalled output beat holds until m_axis_tready
// ----------------------------------------------------------------------------
`default_nettype none

module depth_alpha_pixel_compositor_top import dapc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // src_red, src_green, src_blue, src_alpha, src_depth[32],
  // dst_red, dst_green, dst_blue, dst_alpha, dst_depth[32]
  input  wire logic [127:0] s_axis_tdata,
  // first_layer
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, out_depth[32]
  output logic [63:0]       m_axis_tdata
);

  // unpack the input beat
  logic [7:0]  src_red, src_green, src_blue, src_alpha;
  logic [7:0]  dst_red, dst_green, dst_blue, dst_alpha;
  logic [31:0] src_depth, dst_depth;
  logic        first_layer;

  assign src_red     = s_axis_tdata[7:0];
  assign src_green   = s_axis_tdata[15:8];
  assign src_blue    = s_axis_tdata[23:16];
  assign src_alpha   = s_axis_tdata[31:24];
  assign src_depth   = s_axis_tdata[63:32];
  assign dst_red     = s_axis_tdata[71:64];
  assign dst_green   = s_axis_tdata[79:72];
  assign dst_blue    = s_axis_tdata[87:80];
  assign dst_alpha   = s_axis_tdata[95:88];
  assign dst_depth   = s_axis_tdata[127:96];
  assign first_layer = s_axis_tuser[0];

  // stage valid bits and per-stage ready, index 0 is stage 1
  logic [NumStages-1:0] valid;
  logic [NumStages-1:0] ready;
  dapc_en_t             en;

  // a stage can load when it is empty or its contents move on
  always_comb begin
    ready[NumStages-1] = !valid[NumStages-1] || m_axis_tready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign en = '{s1: ready[0], s2: ready[1], s3: ready[2], s4: ready[3], s5: ready[4]};
  assign s_axis_tready = ready[0];
  assign m_axis_tvalid = valid[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  // depth test and blend weights
  dapc_coef_t coef;

  dapc_coef u_coef (
    .clk         (clk),
    .en1         (en.s1),
    .src_alpha   (src_alpha),
    .src_depth   (src_depth),
    .dst_alpha   (dst_alpha),
    .dst_depth   (dst_depth),
    .first_layer (first_layer),
    .coef        (coef)
  );

  // three color lanes share the weights
  logic [7:0] out_red, out_green, out_blue, out_alpha;

  dapc_band u_band_red (
    .clk      (clk),
    .en       (en),
    .src_band (src_red),
    .dst_band (dst_red),
    .coef     (coef),
    .out_band (out_red)
  );

  dapc_band u_band_green (
    .clk      (clk),
    .en       (en),
    .src_band (src_green),
    .dst_band (dst_green),
    .coef     (coef),
    .out_band (out_green)
  );

  dapc_band u_band_blue (
    .clk      (clk),
    .en       (en),
    .src_band (src_blue),
    .dst_band (dst_blue),
    .coef     (coef),
    .out_band (out_blue)
  );

  dapc_cov u_cov (
    .clk       (clk),
    .en        (en),
    .src_alpha (src_alpha),
    .dst_alpha (dst_alpha),
    .out_alpha (out_alpha)
  );

  // chosen depth rides along to the output stage
  logic [31:0] depth2, depth3, depth4, depth5;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      depth2 <= coef.depth;
    end
    if (en.s3) begin
      depth3 <= depth2;
    end
    if (en.s4) begin
      depth4 <= depth3;
    end
    if (en.s5) begin
      depth5 <= depth4;
    end
  end

  assign m_axis_tdata = {depth5, out_alpha, out_blue, out_green, out_red};

endmodule

`default_nettype wire

FILE: rtl/core/dapc_checker.sv
// ----------------------------------------------------------------------------
// dapc_checker
// port-level checks of the compositor pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module dapc_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata
);

  // output beat held under stall
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output beat changed under stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output beat right after reset");

  // an empty output stage never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // a beat accepted with the output stage empty and m_axis_tready held high reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid && m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
      |=> m_axis_tvalid)
    else $error("accepted beat did not reach the output");

endmodule

bind depth_alpha_pixel_compositor_top dapc_checker u_dapc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
